/* sv/bcl_pkg.sv */
// bcl_pkg: shared types, codes and reset defaults for the button click detector
// used by every module of the detector but bcl_ram and by its checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bcl_pkg;

   // register reset values and default queue depth
   localparam logic [15:0] DEF_DEBOUNCE_MS   = 16'd20;
   localparam logic [15:0] DEF_LONG_PRESS_MS = 16'd800;
   localparam logic [15:0] DEF_POLL_MS       = 16'd10;
   localparam logic        DEF_SECOND_BUTTON = 1'b1;
   localparam int          QUEUE_DEPTH_DEF   = 8;

   // request kind carried in tuser
   typedef enum logic {
      OP_TICK = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_POLL       = 2'd2,
      CSR_SECOND_BTN = 2'd3
   } csr_index_type;

   // queued event codes
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_A_CLICK = 3'd1,
      EV_A_LONG  = 3'd2,
      EV_B_CLICK = 3'd3,
      EV_B_LONG  = 3'd4
   } ev_code_type;

   // debounce machine phases
   typedef enum logic [1:0] {
      PH_IDLE           = 2'd0,
      PH_PRESS_SETTLE   = 2'd1,
      PH_HELD           = 2'd2,
      PH_RELEASE_SETTLE = 2'd3
   } phase_type;

   // one event posted by a button machine
   typedef struct packed {
      logic        vld;
      ev_code_type code;
   } ev_type;

   // queue status toward the top level
   typedef struct packed {
      logic        busy;
      ev_code_type pop_code;
      logic [2:0]  queued;
   } fifo_stat_type;

endpackage

`default_nettype wire

/* sv/button_click_long_press_detector.sv */
// button_click_long_press_detector: top level, request register, scan gate, response register
// depends on bcl_pkg, bcl_button and bcl_fifo
//
// Two active-low buttons are debounced into click and long-press events held in a
// ring queue of QUEUE_DEPTH entries (QUEUE_DEPTH-1 usable).
// Request channel req_*: tuser selects a tick (time plus pin levels) or a pop.
// A tick is scanned only if poll_period_ms have passed since the last scan;
// button A, then button B when enabled, step through their debounce machines.
// A pop returns the oldest event or none. Every request gives one response on
// rsp_*: the event code and the number of queued events after the request.
// Configuration port csr_*: always ready, written while the block is idle.
// Pipeline: request register, then response register. Throughput: one request per
// cycle while the receiver keeps up; a tick that posts events for both buttons
// holds the request side while the queue ram takes its second write.
// Reset clears the debounce machines, the queue pointers, the scan time and
// restores the register defaults; queue contents are not cleared.
// When the receiver stalls, the response register holds and one more request
// is taken into the request register before req_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module button_click_long_press_detector
   import bcl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // now_ms[31:0], button_a_level, button_b_level, 0
   input  wire logic        req_tuser,   // operation
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // event_code[2:0], queued_events[2:0], 0
   // configuration port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic          item_vld_ff;
   op_type        item_op_ff;
   logic [31:0]   item_now_ff;
   logic          item_a_ff;
   logic          item_b_ff;

   logic          rsp_vld_ff;
   logic [7:0]    rsp_data_ff;

   logic [15:0]   debounce_ff;
   logic [15:0]   long_press_ff;
   logic [15:0]   poll_ff;
   logic          second_btn_ff;
   logic [31:0]   last_scan_ff;

   logic          advance;
   logic          req_fire;
   logic          scan_go;
   logic          pop;
   logic [31:0]   scan_age;
   ev_type        post_a;
   ev_type        post_b;
   fifo_stat_type fifo_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEF_DEBOUNCE_MS;
         long_press_ff <= DEF_LONG_PRESS_MS;
         poll_ff       <= DEF_POLL_MS;
         second_btn_ff <= DEF_SECOND_BUTTON;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   debounce_ff   <= csr_data;
            CSR_LONG_PRESS: long_press_ff <= csr_data;
            CSR_POLL:       poll_ff       <= csr_data;
            CSR_SECOND_BTN: second_btn_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // flow control between request and response registers
   assign advance    = item_vld_ff && (!rsp_vld_ff || rsp_tready) && !fifo_stat.busy;
   assign req_tready = !item_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_tready) begin
         item_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_op_ff  <= op_type'(req_tuser);
         item_now_ff <= req_tdata[31:0];
         item_a_ff   <= req_tdata[32];
         item_b_ff   <= req_tdata[33];
      end
   end

   // poll gate, wrapping time difference
   assign scan_age = item_now_ff - last_scan_ff;
   assign scan_go  = advance && (item_op_ff == OP_TICK) && (scan_age >= {16'd0, poll_ff});
   assign pop      = advance && (item_op_ff == OP_POP);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scan_ff <= '0;
      end else if (scan_go) begin
         last_scan_ff <= item_now_ff;
      end
   end

   // debounce machines
   bcl_button #(
      .CLICK_CODE (EV_A_CLICK),
      .LONG_CODE  (EV_A_LONG)
   ) u_button_a (
      .clock         (clock),
      .reset         (reset),
      .scan          (scan_go),
      .pressed       (!item_a_ff),
      .now_ms        (item_now_ff),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .post          (post_a)
   );

   bcl_button #(
      .CLICK_CODE (EV_B_CLICK),
      .LONG_CODE  (EV_B_LONG)
   ) u_button_b (
      .clock         (clock),
      .reset         (reset),
      .scan          (scan_go && second_btn_ff),
      .pressed       (!item_b_ff),
      .now_ms        (item_now_ff),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .post          (post_b)
   );

   // event queue
   bcl_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .post_a (post_a),
      .post_b (post_b),
      .pop    (pop),
      .stat   (fifo_stat)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, fifo_stat.queued, fifo_stat.pop_code};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* sv/bcl_ram.sv */
// bcl_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bcl_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read-before-write registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/bcl_button.sv */
// bcl_button: four-phase debounce machine of one button with click and long detection
// depends on bcl_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcl_button
   import bcl_pkg::*;
#(
   parameter ev_code_type CLICK_CODE = EV_A_CLICK,
   parameter ev_code_type LONG_CODE  = EV_A_LONG
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        scan,
   input  wire logic        pressed,
   input  wire logic [31:0] now_ms,
   input  wire logic [15:0] debounce_ms,
   input  wire logic [15:0] long_press_ms,
   output ev_type           post
);

   phase_type   phase_ff, phase_in;
   logic [31:0] edge_ff, edge_in;
   logic [31:0] press_ff, press_in;
   logic        long_ff, long_in;
   logic [31:0] edge_age;
   logic [31:0] press_age;
   logic        settled;
   logic        long_due;

   // elapsed times wrap modulo 2^32
   assign edge_age  = now_ms - edge_ff;
   assign press_age = now_ms - press_ff;
   assign settled   = edge_age >= {16'd0, debounce_ms};
   assign long_due  = press_age >= {16'd0, long_press_ms};

   // phase register and timestamps, updated only on a scan
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         edge_ff  <= '0;
         press_ff <= '0;
         long_ff  <= 1'b0;
      end else if (scan) begin
         phase_ff <= phase_in;
         edge_ff  <= edge_in;
         press_ff <= press_in;
         long_ff  <= long_in;
      end
   end

   // next phase and posted event
   always_comb begin
      phase_in  = phase_ff;
      edge_in   = edge_ff;
      press_in  = press_ff;
      long_in   = long_ff;
      post.vld  = 1'b0;
      post.code = CLICK_CODE;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               phase_in = PH_PRESS_SETTLE;
               edge_in  = now_ms;
            end
         end
         PH_PRESS_SETTLE: begin
            if (!pressed) begin
               phase_in = PH_IDLE;
            end else if (settled) begin
               phase_in = PH_HELD;
               press_in = now_ms;
            end
         end
         PH_HELD: begin
            if (!pressed) begin
               phase_in = PH_RELEASE_SETTLE;
               edge_in  = now_ms;
            end else if (!long_ff && long_due) begin
               long_in   = 1'b1;
               post.vld  = scan;
               post.code = LONG_CODE;
            end
         end
         PH_RELEASE_SETTLE: begin
            // a bounce back to pressed restarts the long timer
            if (pressed) begin
               phase_in = PH_HELD;
               press_in = now_ms;
            end else if (settled) begin
               phase_in = PH_IDLE;
               if (long_ff) begin
                  long_in = 1'b0;
               end else begin
                  post.vld  = scan;
                  post.code = CLICK_CODE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/bcl_fifo.sv */
// bcl_fifo: ring event queue holding up to depth-1 events, two posts or one pop per request
// depends on bcl_pkg and bcl_ram
`timescale 1ns / 1ps
`default_nettype none

module bcl_fifo
   import bcl_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ev_type post_a,
   input  wire ev_type post_b,
   input  wire logic pop,
   output fifo_stat_type stat
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]   CAP  = (AW + 1)'(QUEUE_DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] count_ff, count_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [AW-1:0] pend_addr_ff;
   ev_code_type   pend_code_ff;
   logic          byp_vld_ff, byp_vld_in;
   ev_code_type   byp_code_ff;

   ev_type        first;
   ev_type        second;
   logic          acc1, acc2, pop_ok;
   logic [AW-1:0] tail_p1, tail_p2;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   ev_code_type   wr_code;
   logic [2:0]    rd_bits;
   ev_code_type   head_code;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
      wrap_inc = (x == LAST) ? '0 : x + AW'(1);
   endfunction

   // order posts: button A first, B fills in when A is quiet
   always_comb begin
      first  = post_a.vld ? post_a : post_b;
      second = post_b;
      second.vld = post_a.vld & post_b.vld;
   end

   // room checks, an event posted while full is dropped
   assign acc1   = first.vld && (count_ff != LAST);
   assign acc2   = second.vld && (({1'b0, count_ff} + (AW + 1)'(2)) <= CAP);
   assign pop_ok = pop && (count_ff != '0);

   assign tail_p1 = wrap_inc(tail_ff);
   assign tail_p2 = wrap_inc(tail_p1);

   assign tail_in  = acc2 ? tail_p2 : (acc1 ? tail_p1 : tail_ff);
   assign head_in  = pop_ok ? wrap_inc(head_ff) : head_ff;
   assign count_in = count_ff + AW'(acc1) + AW'(acc2) - AW'(pop_ok);

   // second event of a request is written in the next cycle, when the write port is free
   assign pend_vld_in = acc2;

   // write port: deferred event first, else the first new event
   always_comb begin
      if (pend_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_code = pend_code_ff;
      end else begin
         wr_en   = acc1;
         wr_addr = tail_ff;
         wr_code = first.code;
      end
   end

   // a write to the address read this cycle is forwarded
   assign byp_vld_in = wr_en && (wr_addr == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         byp_vld_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         byp_vld_ff  <= byp_vld_in;
      end
   end

   // payload of the deferred write and of the forward path
   always_ff @(posedge clock) begin
      pend_addr_ff <= tail_p1;
      pend_code_ff <= second.code;
      byp_code_ff  <= wr_code;
   end

   bcl_ram #(
      .WIDTH ($bits(ev_code_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_code),
      .rd_addr (head_in),
      .rd_data (rd_bits)
   );

   assign head_code = byp_vld_ff ? byp_code_ff : ev_code_type'(rd_bits);

   // status toward the top level
   always_comb begin
      stat.busy     = pend_vld_ff;
      stat.pop_code = pop_ok ? head_code : EV_NONE;
      stat.queued   = 3'(count_in);
   end

endmodule

`default_nettype wire

/* sv/bcl_check.sv */
// bcl_check: port-level checker for the button click detector, bound to the top level
// depends on bcl_pkg and button_click_long_press_detector
`timescale 1ns / 1ps
`default_nettype none

module bcl_check
   import bcl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   // no response is left over from before reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // only defined event codes and zero padding leave the block
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[2:0] <= EV_B_LONG) && (rsp_tdata[7:6] == 2'b00)))
      else $error("undefined event code in response");

   // a request taken into an empty pipeline is answered from the response register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid && !$past(req_tvalid && req_tready))
         |=> ##1 rsp_tvalid)
      else $error("response missing after request");

endmodule

bind button_click_long_press_detector bcl_check u_bcl_check (.*);

`default_nettype wire

/* verif/button_click_long_press_detector_test.sv */
// button_click_long_press_detector_test: self-checking bench for the two-button detector
// drives tick and pop requests with random gaps and stalls, checks every response
// against its own debounce and event queue prediction; depends on bcl_pkg and the rtl
`timescale 1ns / 1ps

module button_click_long_press_detector_test
   import bcl_pkg::*;
;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 215;
   localparam int RING_DEPTH   = QUEUE_DEPTH_DEF;

   // predicted detector state and the responses it implies
   class detector_scoreboard;
      typedef struct packed {
         ev_code_type code;
         logic [2:0]  queued;
      } expected_rsp_type;

      logic [15:0]      debounce_ms;
      logic [15:0]      long_press_ms;
      logic [15:0]      poll_ms;
      logic             second_btn;
      phase_type        btn_phase [2];
      logic [31:0]      edge_stamp [2];
      logic [31:0]      press_stamp [2];
      bit               long_done [2];
      ev_code_type      ring [RING_DEPTH];
      int unsigned      head;
      int unsigned      tail;
      logic [31:0]      last_scan;
      expected_rsp_type pending [$];
      int               errors;

      function new();
         debounce_ms   = DEF_DEBOUNCE_MS;
         long_press_ms = DEF_LONG_PRESS_MS;
         poll_ms       = DEF_POLL_MS;
         second_btn    = DEF_SECOND_BUTTON;
         for (int b = 0; b < 2; b++) begin
            btn_phase[b]   = PH_IDLE;
            edge_stamp[b]  = '0;
            press_stamp[b] = '0;
            long_done[b]   = 1'b0;
         end
         head      = 0;
         tail      = 0;
         last_scan = '0;
         errors    = 0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_DEBOUNCE:   debounce_ms   = value;
            CSR_LONG_PRESS: long_press_ms = value;
            CSR_POLL:       poll_ms       = value;
            CSR_SECOND_BTN: second_btn    = value[0];
            default: ;
         endcase
      endfunction

      // drop the event when the ring is full
      function void post_event(ev_code_type code);
         if ((tail + 1) % RING_DEPTH != head) begin
            ring[tail] = code;
            tail = (tail + 1) % RING_DEPTH;
         end
      endfunction

      // one step of the debounce machine of one button
      function void scan_button(int idx, bit pressed, logic [31:0] now);
         ev_code_type click_ev;
         ev_code_type long_ev;
         logic [31:0] since_edge;
         logic [31:0] since_press;
         click_ev    = (idx == 0) ? EV_A_CLICK : EV_B_CLICK;
         long_ev     = (idx == 0) ? EV_A_LONG : EV_B_LONG;
         since_edge  = now - edge_stamp[idx];
         since_press = now - press_stamp[idx];
         case (btn_phase[idx])
            PH_IDLE: begin
               if (pressed) begin
                  btn_phase[idx]  = PH_PRESS_SETTLE;
                  edge_stamp[idx] = now;
               end
            end
            PH_PRESS_SETTLE: begin
               if (!pressed) begin
                  btn_phase[idx] = PH_IDLE;
               end else if (since_edge >= {16'd0, debounce_ms}) begin
                  btn_phase[idx]   = PH_HELD;
                  press_stamp[idx] = now;
               end
            end
            PH_HELD: begin
               if (!pressed) begin
                  btn_phase[idx]  = PH_RELEASE_SETTLE;
                  edge_stamp[idx] = now;
               end else if (!long_done[idx] && since_press >= {16'd0, long_press_ms}) begin
                  long_done[idx] = 1'b1;
                  post_event(long_ev);
               end
            end
            default: begin
               // a bounce back restarts the long-press timer
               if (pressed) begin
                  btn_phase[idx]   = PH_HELD;
                  press_stamp[idx] = now;
               end else if (since_edge >= {16'd0, debounce_ms}) begin
                  btn_phase[idx] = PH_IDLE;
                  if (long_done[idx]) long_done[idx] = 1'b0;
                  else post_event(click_ev);
               end
            end
         endcase
      endfunction

      function void note_request(op_type op, logic [31:0] now, logic lvl_a, logic lvl_b);
         expected_rsp_type exp_rsp;
         logic [31:0]      since_scan;
         exp_rsp.code = EV_NONE;
         since_scan   = now - last_scan;
         if (op == OP_TICK) begin
            if (since_scan >= {16'd0, poll_ms}) begin
               last_scan = now;
               scan_button(0, !lvl_a, now);
               if (second_btn) scan_button(1, !lvl_b, now);
            end
         end else if (head != tail) begin
            exp_rsp.code = ring[head];
            head = (head + 1) % RING_DEPTH;
         end
         exp_rsp.queued = 3'((tail + RING_DEPTH - head) % RING_DEPTH);
         pending.push_back(exp_rsp);
      endfunction

      task check_response(logic [7:0] data);
         expected_rsp_type exp_rsp;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", data));
         end else begin
            exp_rsp = pending.pop_front();
            if (data[2:0] != exp_rsp.code)
               report_mismatch($sformatf("event_code %0d, predicted %0d", data[2:0],
                                         exp_rsp.code));
            if (data[5:3] != exp_rsp.queued)
               report_mismatch($sformatf("queued_events %0d, predicted %0d", data[5:3],
                                         exp_rsp.queued));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // now_ms[31:0], button_a_level, button_b_level, 0
   logic        req_tuser;    // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // event_code[2:0], queued_events[2:0], 0
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   detector_scoreboard sb = new();

   int          cycle_count = 0;
   int          rsp_total = 0;
   bit          long_hold_done = 1'b0;
   int          burst_left = 0;

   // time base and pin schedule of the random part
   logic [31:0] clock_ms;
   logic        pin_level [2];
   int          hold_left [2];
   int          cfg_debounce;
   int          cfg_long;
   int          cfg_poll;

   button_click_long_press_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watch all three handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[31:0], req_tdata[32],
                            req_tdata[33]);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
            rsp_total++;
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: ready runs, random stalls and one long hold-off
   initial begin
      int run_len;
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 80);
         repeat (run_len) @(posedge clock);
         if (!long_hold_done && rsp_total >= 500) begin
            long_hold_done = 1'b1;
            stall = 300;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   task automatic send_request(op_type op, logic [31:0] now, logic lvl_a, logic lvl_b);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, lvl_b, lvl_a, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering requests until every response is back
   task automatic wait_all_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // valid stays up across back to back writes, the caller drops it
   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(int deb, int lng, int poll, logic second);
      write_csr(CSR_DEBOUNCE, 16'(deb));
      write_csr(CSR_LONG_PRESS, 16'(lng));
      write_csr(CSR_POLL, 16'(poll));
      write_csr(CSR_SECOND_BTN, {15'($urandom), second});
      csr_valid <= 1'b0;
      cfg_debounce = deb;
      cfg_long     = lng;
      cfg_poll     = poll;
   endtask

   // time advance scaled to the current settings
   function automatic logic [31:0] pick_step();
      int unsigned unit;
      int r;
      unit = cfg_poll;
      if (cfg_debounce > unit) unit = cfg_debounce;
      if (unit == 0) unit = 1;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 9) return $urandom();
      if (r < 24) return $urandom_range(cfg_long / 2, cfg_long + unit);
      if (r < 40) return $urandom_range(0, unit);
      return $urandom_range(unit, unit * 2);
   endfunction

   // level hold length in ticks: bounces, ordinary presses, long holds
   function automatic int pick_hold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 1;
      if (r < 75) return $urandom_range(2, 6);
      return $urandom_range(8, 20);
   endfunction

   task automatic run_random(int count);
      int pop_pct;
      int chunk_left;
      chunk_left = 0;
      pop_pct    = 30;
      for (int i = 0; i < count; i++) begin
         if (chunk_left == 0) begin
            // vary the pop rate so the queue both fills up and runs dry
            case ($urandom_range(0, 3))
               0: pop_pct = 0;
               1: pop_pct = 15;
               2: pop_pct = 35;
               default: pop_pct = 70;
            endcase
            chunk_left = $urandom_range(20, 50);
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(15, 40);
         end
         chunk_left--;
         if (i == count / 2) wait_all_done();
         if ($urandom_range(0, 99) < pop_pct) begin
            send_request(OP_POP, $urandom(), 1'($urandom), 1'($urandom));
         end else begin
            clock_ms = clock_ms + pick_step();
            for (int b = 0; b < 2; b++) begin
               if (hold_left[b] == 0) begin
                  pin_level[b] = !pin_level[b];
                  hold_left[b] = pick_hold();
               end
               hold_left[b]--;
            end
            if ($urandom_range(0, 99) < 8)
               send_request(OP_TICK, clock_ms, 1'($urandom), 1'($urandom));
            else
               send_request(OP_TICK, clock_ms, pin_level[0], pin_level[1]);
         end
      end
      wait_all_done();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_TICK;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DEBOUNCE;
      csr_data   <= '0;
      cfg_debounce = DEF_DEBOUNCE_MS;
      cfg_long     = DEF_LONG_PRESS_MS;
      cfg_poll     = DEF_POLL_MS;
      pin_level[0] = 1'b1;
      pin_level[1] = 1'b1;
      hold_left[0] = 3;
      hold_left[1] = 5;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings
      send_request(OP_TICK, 32'd0, 1'b0, 1'b0);    // too early after reset
      send_request(OP_POP, 32'hFFFF_FFFF, 1'b1, 1'b1);   // empty queue
      send_request(OP_TICK, 32'd9, 1'b0, 1'b0);    // still too early
      send_request(OP_TICK, 32'd10, 1'b0, 1'b0);   // both start settling
      send_request(OP_TICK, 32'd30, 1'b0, 1'b0);   // both held
      send_request(OP_TICK, 32'd40, 1'b1, 1'b0);   // a release settling
      send_request(OP_TICK, 32'd45, 1'b0, 1'b0);   // inside poll period
      send_request(OP_TICK, 32'd50, 1'b0, 1'b0);   // a release bounce, back to held
      send_request(OP_TICK, 32'd60, 1'b1, 1'b0);
      send_request(OP_TICK, 32'd80, 1'b1, 1'b0);   // a click
      send_request(OP_TICK, 32'd830, 1'b1, 1'b0);  // b long
      send_request(OP_TICK, 32'd900, 1'b1, 1'b1);
      send_request(OP_TICK, 32'd920, 1'b1, 1'b1);  // release after long, no click
      send_request(OP_POP, 32'd0, 1'b0, 1'b0);
      send_request(OP_POP, 32'h5555_AAAA, 1'b0, 1'b1);
      send_request(OP_POP, 32'hAAAA_5555, 1'b1, 1'b0);
      // time wraps through zero
      send_request(OP_TICK, 32'hFFFF_FFF0, 1'b0, 1'b0);
      send_request(OP_TICK, 32'h0000_0010, 1'b0, 1'b0);
      send_request(OP_TICK, 32'h0000_0020, 1'b1, 1'b1);
      send_request(OP_TICK, 32'h0000_0040, 1'b1, 1'b1);
      send_request(OP_POP, 32'd0, 1'b0, 1'b0);
      send_request(OP_POP, 32'd0, 1'b0, 1'b0);
      wait_all_done();
      clock_ms = 32'h0000_1000;

      run_random(PHASE_ITEMS);
      // zero periods
      load_settings(0, 0, 0, 1'b1);
      run_random(PHASE_ITEMS);
      // button b frozen
      load_settings(5, 40, 3, 1'b0);
      run_random(PHASE_ITEMS);
      // largest settings
      load_settings(65535, 65535, 65535, 1'b1);
      run_random(PHASE_ITEMS);
      load_settings(2, 15, 0, 1'b1);
      run_random(PHASE_ITEMS);
      load_settings(30, 200, 7, 1'b1);
      run_random(PHASE_ITEMS);

      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending.size()));
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
